>>> hdl/topk_heap_with_labels_sorted_macros.svh
// Assertion macros shared by the top-k heap design.
`ifndef TOPK_HEAP_WITH_LABELS_SORTED_MACROS_SVH
`define TOPK_HEAP_WITH_LABELS_SORTED_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define TKH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define TKH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hdl/tkh_pkg.sv
// Package with shared types and float compare for the top-k heap.
package tkh_pkg;
  localparam int unsigned ValueW = 32;
  localparam int unsigned LabelW = 64;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 7;
  localparam logic [CfgIdxW-1:0] CfgKeepCount = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgKeepSmallest = 1'd1;

  typedef logic [ValueW-1:0] value_t;
  typedef logic signed [LabelW-1:0] label_t;

  typedef struct packed {
    value_t value;
    label_t label;
  } entry_t;

  // IEEE single less-than; false when either operand is NaN.
  function automatic logic f_lt(value_t a, value_t b);
    logic a_nan;
    logic b_nan;
    logic a_zero;
    logic b_zero;
    logic res;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    if (a_nan || b_nan || (a_zero && b_zero)) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = a[31];
    end else if (a[31]) begin
      res = a[30:0] > b[30:0];
    end else begin
      res = a[30:0] < b[30:0];
    end
    return res;
  endfunction
endpackage

>>> hdl/tkh_if.sv
// Valid/ready channel interface carrying a payload.
interface tkh_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/topk_heap_with_labels_sorted.sv
// Top level of the top-k selector with in-place heapsort output.
//
// The block keeps the best keep_count candidates of a set in a binary heap
// held in one memory with a registered read port. With keep_smallest clear
// it keeps the largest values and emits them in descending order. With it
// set it keeps the smallest and emits them ascending. Values compare as IEEE
// singles through one shared comparator. A word is taken only while the
// block is idle and no register write is under way. While the heap is not
// yet full, a word rises level by level (read the parent, then compare and
// write). Once the heap is full, a word is first tested against the root.
// If it wins, it then sinks level by level (read both children, compare
// them, compare the pick with the word and write). Equal or unordered
// children send it to the right. These steps come from the heap depth and
// the single memory port. On the word marked end_of_set the block heapsorts
// the n kept entries in place. It then streams the n result words best-first
// while out_ready is high; the last word has out_last set. A stalled receiver
// holds the block, and with it the input. Any configuration write empties
// the heap.
`include "topk_heap_with_labels_sorted_macros.svh"
module topk_heap_with_labels_sorted
  import tkh_pkg::*;
#(
  parameter int unsigned MAX_KEEP = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  value_t              in_cand_value,
  input  label_t              in_cand_label,
  input  logic                in_end_of_set,
  output logic                out_valid,
  input  logic                out_ready,
  output value_t              out_out_value,
  output label_t              out_out_label,
  output logic                out_out_last
);
  localparam int unsigned AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int unsigned CW = $clog2(MAX_KEEP + 1) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_RT_RD, S_RT_CMP, S_DN_RDL, S_DN_RDR,
    S_DN_CMPC, S_DN_CMPP, S_DN_PUT, S_SORT, S_SORT_TOP, S_SORT_LD,
    S_SORT_WR, S_OUT_RD, S_OUT_WT
  } state_t;

  state_t state_r;
  logic [6:0] keep_count_r;
  logic keep_smallest_r;
  logic [CW-1:0] fill_r;      // entries in heap
  logic [CW-1:0] n_r;         // active heap size during sift-down
  logic [CW-1:0] pos_r;       // 1-based hole position
  logic [CW-1:0] pick_r;      // 1-based slot of the chosen child
  logic [CW-1:0] sort_j_r;    // sort: last slot of the shrinking heap
  entry_t item_r;
  entry_t lchild_r;
  entry_t pick_e_r;
  entry_t top_r;
  logic eos_r;
  logic sorting_r;
  entry_t mem [MAX_KEEP];
  entry_t rd_r;
  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  entry_t wr_data;
  logic [CW-1:0] k_eff;
  value_t cmp_a;
  value_t cmp_b;
  logic cmp_res;
  logic [CW-1:0] out_cnt_r;
  entry_t out_r;
  logic out_last_r;
  logic out_valid_r;
  logic out_load;
  logic out_is_last;

  tkh_cmp u_cmp (
    .smallest(keep_smallest_r),
    .a(cmp_a),
    .b(cmp_b),
    .nearer(cmp_res)
  );

  // Clamp the configured count to 1..MAX_KEEP.
  always_comb begin
    if (keep_count_r == 7'd0) begin
      k_eff = CW'(1);
    end else if (32'(keep_count_r) > MAX_KEEP) begin
      k_eff = CW'(MAX_KEEP);
    end else begin
      k_eff = CW'(keep_count_r);
    end
  end

  // The output register takes a new word when it is empty or being drained.
  assign out_is_last = (out_cnt_r + CW'(1)) == fill_r;
  assign out_load = (state_r == S_OUT_WT) && (!out_valid_r || out_ready) && !cfg_we;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Comparator operand selection and memory port control.
  always_comb begin
    cmp_a = item_r.value;
    cmp_b = rd_r.value;
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = AW'(pos_r - CW'(1));
    wr_data = item_r;
    unique case (state_r)
      S_UP_RD: begin
        rd_en = 1'b1;
        rd_addr = AW'((pos_r >> 1) - CW'(1));
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (pos_r > CW'(1) && cmp_res) begin
          wr_data = rd_r;
        end
      end
      S_RT_RD: begin
        rd_en = 1'b1;
      end
      S_RT_CMP: begin
        cmp_a = rd_r.value;
        cmp_b = item_r.value;
      end
      S_DN_RDL: begin
        rd_en = 1'b1;
        rd_addr = AW'((pos_r << 1) - CW'(1));
      end
      S_DN_RDR: begin
        if ((pos_r << 1) != n_r) begin
          rd_en = 1'b1;
          rd_addr = AW'(pos_r << 1);
        end
      end
      S_DN_CMPC: begin
        cmp_a = lchild_r.value;
        cmp_b = rd_r.value;
      end
      S_DN_CMPP: begin
        cmp_a = pick_e_r.value;
        cmp_b = item_r.value;
        wr_en = 1'b1;
        if (cmp_res) begin
          wr_data = pick_e_r;
        end
      end
      S_DN_PUT: begin
        wr_en = 1'b1;
      end
      S_SORT: begin
        rd_en = 1'b1;
      end
      S_SORT_TOP: begin
        rd_en = 1'b1;
        rd_addr = AW'(sort_j_r);
      end
      S_SORT_WR: begin
        wr_en = 1'b1;
        wr_addr = AW'(sort_j_r);
        wr_data = top_r;
      end
      S_OUT_RD: begin
        rd_en = 1'b1;
        rd_addr = AW'(out_cnt_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      keep_count_r <= 7'd64;
      keep_smallest_r <= 1'b0;
      fill_r <= '0;
      out_valid_r <= 1'b0;
      sorting_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CfgKeepCount: keep_count_r <= cfg_data;
          CfgKeepSmallest: keep_smallest_r <= cfg_data[0];
          default: begin
          end
        endcase
        fill_r <= '0;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (in_valid) begin
              item_r <= '{value: in_cand_value, label: in_cand_label};
              eos_r <= in_end_of_set;
              sorting_r <= 1'b0;
              if (fill_r < k_eff) begin
                fill_r <= fill_r + CW'(1);
                pos_r <= fill_r + CW'(1);
                state_r <= (fill_r == '0) ? S_UP_CMP : S_UP_RD;
              end else begin
                state_r <= S_RT_RD;
              end
            end
          end
          S_UP_RD: state_r <= S_UP_CMP;
          S_UP_CMP: begin
            if (pos_r > CW'(1) && cmp_res) begin
              pos_r <= pos_r >> 1;
              state_r <= (pos_r > CW'(3)) ? S_UP_RD : S_UP_CMP;
            end else begin
              state_r <= eos_r ? S_SORT : S_IDLE;
              sort_j_r <= fill_r - CW'(1);
            end
          end
          S_RT_RD: state_r <= S_RT_CMP;
          // Root compare: only a strictly better word replaces the root.
          S_RT_CMP: begin
            if (cmp_res) begin
              pos_r <= CW'(1);
              n_r <= fill_r;
              state_r <= (fill_r < CW'(2)) ? S_DN_PUT : S_DN_RDL;
            end else begin
              state_r <= eos_r ? S_SORT : S_IDLE;
              sort_j_r <= fill_r - CW'(1);
            end
          end
          S_DN_RDL: state_r <= S_DN_RDR;
          S_DN_RDR: begin
            lchild_r <= rd_r;
            if ((pos_r << 1) == n_r) begin
              pick_r <= pos_r << 1;
              pick_e_r <= rd_r;
              state_r <= S_DN_CMPP;
            end else begin
              state_r <= S_DN_CMPC;
            end
          end
          S_DN_CMPC: begin
            if (cmp_res) begin
              pick_r <= pos_r << 1;
              pick_e_r <= lchild_r;
            end else begin
              pick_r <= (pos_r << 1) + CW'(1);
              pick_e_r <= rd_r;
            end
            state_r <= S_DN_CMPP;
          end
          S_DN_CMPP: begin
            if (cmp_res) begin
              pos_r <= pick_r;
              state_r <= ((pick_r << 1) > n_r) ? S_DN_PUT : S_DN_RDL;
            end else if (sorting_r) begin
              state_r <= S_SORT_WR;
            end else begin
              state_r <= eos_r ? S_SORT : S_IDLE;
              sort_j_r <= fill_r - CW'(1);
            end
          end
          S_DN_PUT: begin
            if (sorting_r) begin
              state_r <= S_SORT_WR;
            end else begin
              state_r <= eos_r ? S_SORT : S_IDLE;
              sort_j_r <= fill_r - CW'(1);
            end
          end
          // Move the root behind the shrinking heap until one entry is left.
          S_SORT: begin
            if (sort_j_r == '0) begin
              out_cnt_r <= '0;
              state_r <= S_OUT_RD;
            end else begin
              state_r <= S_SORT_TOP;
            end
          end
          S_SORT_TOP: begin
            top_r <= rd_r;
            state_r <= S_SORT_LD;
          end
          S_SORT_LD: begin
            item_r <= rd_r;
            n_r <= sort_j_r;
            pos_r <= CW'(1);
            sorting_r <= 1'b1;
            state_r <= (sort_j_r < CW'(2)) ? S_DN_PUT : S_DN_RDL;
          end
          S_SORT_WR: begin
            sort_j_r <= sort_j_r - CW'(1);
            state_r <= S_SORT;
          end
          S_OUT_RD: state_r <= S_OUT_WT;
          S_OUT_WT: begin
            if (!out_valid_r || out_ready) begin
              out_r <= rd_r;
              out_last_r <= out_is_last;
              if (out_is_last) begin
                fill_r <= '0;
                state_r <= S_IDLE;
              end else begin
                out_cnt_r <= out_cnt_r + CW'(1);
                state_r <= S_OUT_RD;
              end
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  assign in_ready = (state_r == S_IDLE) && !cfg_we;
  assign out_valid = out_valid_r;
  assign out_out_value = out_r.value;
  assign out_out_label = out_r.label;
  assign out_out_last = out_last_r;

  `TKH_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CW'(MAX_KEEP))
  `TKH_ASSERT_IMP(a_no_in_busy, clk, rst_n, state_r != S_IDLE, !in_ready)
  `TKH_ASSERT_NEXT(a_last_clears, clk, rst_n, out_load && out_is_last, fill_r == '0 && out_out_last)
  `TKH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_out_value))
endmodule

>>> hdl/tkh_cmp.sv
// Shared compare unit: mode-dependent "nearer the root" test.
module tkh_cmp
  import tkh_pkg::*;
(
  input  logic   smallest,
  input  value_t a,
  input  value_t b,
  output logic   nearer
);
  assign nearer = smallest ? f_lt(b, a) : f_lt(a, b);
endmodule

>>> sim/testbench.sv
// Self-checking testbench for the top-k heap selector with sorted output.
`timescale 1ns / 100ps

module testbench;
  import tkh_pkg::*;

  // One candidate word on the input channel and one result word on the output.
  typedef struct packed {
    value_t value;
    label_t label;
    logic   eos;
  } cand_t;

  typedef struct packed {
    value_t value;
    label_t label;
    logic   last;
  } pick_t;

  localparam int unsigned KeepMax = 64;
  localparam int unsigned CycleLimit = 1500000;
  // Extra cycles after the block is back to idle.
  localparam int unsigned SiftSettle = 2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  tkh_if #(.payload_t(cand_t)) in_if (clk);
  tkh_if #(.payload_t(pick_t)) out_if (clk);

  value_t o_value;
  label_t o_label;
  logic o_last;
  assign out_if.data = '{value: o_value, label: o_label, last: o_last};

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  always #4 clk = ~clk;

  topk_heap_with_labels_sorted #(.MAX_KEEP(KeepMax)) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .in_cand_value (in_if.data.value),
    .in_cand_label (in_if.data.label),
    .in_end_of_set (in_if.data.eos),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_out_value (o_value),
    .out_out_label (o_label),
    .out_out_last  (o_last)
  );

  // Shadow of the block: its heap, fill level and both registers.
  value_t heap_val [KeepMax];
  label_t heap_lab [KeepMax];
  int unsigned heap_fill = 0;
  logic [CfgDataW-1:0] keep_cnt = 7'd64;
  logic keep_small = 1'b0;

  pick_t picks_due[$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  bit quiet = 1'b0;     // no idling on either side when set
  bit hold_req = 1'b0;  // ask the receiver for one long hold
  bit tx_high = 1'b0;   // valid is currently driven high

  // Float less-than on raw bits: NaN is unordered and both zeros are equal.
  // Mapping the sign-magnitude pattern to a monotonic key gives the order.
  function automatic bit flt_less(value_t a, value_t b);
    bit a_nan;
    bit b_nan;
    logic [31:0] ka;
    logic [31:0] kb;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
    if (a_nan || b_nan || (a[30:0] == 0 && b[30:0] == 0)) return 1'b0;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    return ka < kb;
  endfunction

  // True when a belongs closer to the root than b in the current mode.
  function automatic bit closer_root(value_t a, value_t b);
    return keep_small ? flt_less(b, a) : flt_less(a, b);
  endfunction

  function automatic void heap_raise(int unsigned pos, value_t v, label_t l);
    int unsigned i;
    i = pos;
    while (i > 1 && closer_root(v, heap_val[i/2 - 1])) begin
      heap_val[i-1] = heap_val[i/2 - 1];
      heap_lab[i-1] = heap_lab[i/2 - 1];
      i = i / 2;
    end
    heap_val[i-1] = v;
    heap_lab[i-1] = l;
  endfunction

  // Put (v,l) at the root of a heap of size n and sink it. Equal or
  // unordered children send it to the right.
  function automatic void heap_sink(int unsigned n, value_t v, label_t l);
    int unsigned i;
    int unsigned c;
    int unsigned p;
    i = 1;
    forever begin
      c = 2 * i;
      if (c > n) break;
      p = (c == n || closer_root(heap_val[c-1], heap_val[c])) ? c : c + 1;
      if (!closer_root(heap_val[p-1], v)) break;
      heap_val[i-1] = heap_val[p-1];
      heap_lab[i-1] = heap_lab[p-1];
      i = p;
    end
    heap_val[i-1] = v;
    heap_lab[i-1] = l;
  endfunction

  // Fold one accepted candidate into the shadow heap; on the end of a set,
  // heapsort in place and queue the whole sorted run.
  function automatic void select_cand(cand_t c);
    int unsigned k;
    int unsigned n;
    int unsigned last;
    value_t tv;
    label_t tl;
    k = (keep_cnt == 0) ? 1 : (keep_cnt > KeepMax) ? KeepMax : keep_cnt;
    if (heap_fill < k) begin
      heap_fill++;
      heap_raise(heap_fill, c.value, c.label);
    end else if (closer_root(heap_val[0], c.value)) begin
      heap_sink(heap_fill, c.value, c.label);
    end
    if (!c.eos) return;
    n = heap_fill;
    for (int unsigned j = 0; j + 1 < n; j++) begin
      last = n - j - 1;
      tv = heap_val[0];
      tl = heap_lab[0];
      heap_sink(last, heap_val[last], heap_lab[last]);
      heap_val[last] = tv;
      heap_lab[last] = tl;
    end
    for (int unsigned j = 0; j < n; j++)
      picks_due.push_back('{value: heap_val[j], label: heap_lab[j], last: (j + 1 == n)});
    heap_fill = 0;
  endfunction

  // Mix of random bits, special values and a small pool that forces ties.
  function automatic value_t pick_value();
    value_t specials [8] = '{32'h7F80_0000, 32'hFF80_0000, 32'h0000_0000,
                             32'h8000_0000, 32'h7FC0_0000, 32'h7F7F_FFFF,
                             32'h0000_0001, 32'hFF7F_FFFF};
    value_t tie_pool [4] = '{32'h3F80_0000, 32'h4000_0000, 32'hBF80_0000,
                             32'h3F80_0000};
    case ($urandom_range(0, 9))
      0: return specials[$urandom_range(0, 7)];
      1, 2: return tie_pool[$urandom_range(0, 3)];
      default: return $urandom;
    endcase
  endfunction

  // Drive one word, wait for the handshake and update the prediction.
  task automatic send_cand(value_t v, label_t l, logic eos);
    int unsigned gap;
    in_if.data <= '{value: v, label: l, eos: eos};
    in_if.valid <= 1'b1;
    tx_high = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    select_cand('{value: v, label: l, eos: eos});
    n_sent++;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      tx_high = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_rand(logic eos);
    send_cand(pick_value(), {$urandom, $urandom}, eos);
  endtask

  // Lower valid once no further word follows straight away.
  task automatic stop_input();
    if (tx_high) begin
      in_if.valid <= 1'b0;
      tx_high = 1'b0;
      @(posedge clk);
    end
  endtask

  // Wait for the queue to drain and for the block to return to idle.
  task automatic wait_quiet();
    stop_input();
    while (picks_due.size() != 0 || !in_if.ready) @(posedge clk);
    repeat (SiftSettle) @(posedge clk);
  endtask

  // Register write; every write also empties the heap.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgKeepCount) keep_cnt = data;
    else keep_small = data[0];
    heap_fill = 0;
  endtask

  task automatic send_set(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_rand(i + 1 == len);
  endtask

  // Infinities, both zeros, NaN, extreme labels and ties, in both modes.
  task automatic test_extremes();
    for (int m = 0; m < 2; m++) begin
      write_reg(CfgKeepSmallest, CfgDataW'(m));
      write_reg(CfgKeepCount, 7'd4);
      send_cand(32'h7F80_0000, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b0);
      send_cand(32'hFF80_0000, 64'sh8000_0000_0000_0000, 1'b0);
      send_cand(32'h0000_0000, 64'sh0, 1'b0);
      send_cand(32'h8000_0000, -64'sh1, 1'b0);
      send_cand(32'h7FC0_0000, 64'sh5, 1'b0);
      send_cand(32'h3F80_0000, 64'sh6, 1'b0);
      send_cand(32'h3F80_0000, 64'sh7, 1'b0);
      send_cand(32'hFFFF_FFFF, 64'sh8, 1'b1);
    end
  endtask

  // Count zero acts as one, an oversized count as the maximum, a short
  // set emits only what arrived.
  task automatic test_counts();
    write_reg(CfgKeepSmallest, 7'd0);
    write_reg(CfgKeepCount, 7'd0);
    send_set(3);
    write_reg(CfgKeepCount, 7'd127);
    send_set(3);
    write_reg(CfgKeepCount, 7'd1);
    send_set(1);
  endtask

  // A register write in the middle of a set drops what was received.
  task automatic test_dropped_set();
    write_reg(CfgKeepCount, 7'd5);
    for (int i = 0; i < 4; i++) send_rand(1'b0);
    write_reg(CfgKeepCount, 7'd3);
    send_set(4);
  endtask

  // The receiver holds off for a long stretch while full sets keep coming.
  task automatic test_backpressure();
    write_reg(CfgKeepCount, 7'd64);
    hold_req = 1'b1;
    send_set(70);
    send_set(66);
    hold_req = 1'b0;
    // The sender stays quiet until every result has drained.
    stop_input();
    while (picks_due.size() != 0) @(posedge clk);
  endtask

  // Mostly small k and well-formed sets; some broken sets and a few at
  // the largest size.
  task automatic test_random();
    int unsigned len;
    int unsigned k;
    while (n_sent < 460) begin
      if (n_sent > 400) quiet = 1'b1;
      if ($urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 9))
          0: k = 64;
          1: k = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
          default: k = $urandom_range(1, 10);
        endcase
        write_reg(CfgKeepSmallest, CfgDataW'($urandom_range(0, 1)));
        write_reg(CfgKeepCount, CfgDataW'(k));
      end
      k = (keep_cnt == 0) ? 1 : (keep_cnt > KeepMax) ? KeepMax : keep_cnt;
      len = $urandom_range(1, k + 6);
      if ($urandom_range(0, 9) == 0) begin
        for (int unsigned i = 0; i < len; i++) send_rand(1'b0);
        write_reg(CfgKeepCount, keep_cnt);
      end else begin
        send_set(len);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_counts();
    test_dropped_set();
    test_backpressure();
    test_random();
    stop_input();
    while (picks_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold when asked.
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 600;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation; also
  // watches the cycle limit.
  int unsigned n_cycles = 0;
  pick_t want;
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (picks_due.size() == 0) begin
        $error("result word with nothing expected: value %h", out_if.data.value);
        n_errors++;
      end else begin
        want = picks_due.pop_front();
        if (out_if.data.value !== want.value) begin
          $error("out_value: expected %h, got %h", want.value, out_if.data.value);
          n_errors++;
        end
        if (out_if.data.label !== want.label) begin
          $error("out_label: expected %h, got %h", want.label, out_if.data.label);
          n_errors++;
        end
        if (out_if.data.last !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, out_if.data.last);
          n_errors++;
        end
      end
    end
  end

endmodule
